// ----- rtl/core/rsm_pkg.sv -----
// package with shared types, constants and helpers for the streaming modexp block
`timescale 1ns / 1ps
`default_nettype none
package rsm_pkg;

    localparam int MaxKeyBits = 32;
    localparam int ExpBits    = 32;
    localparam int CfgBits    = 32;
    localparam int ByteBits   = 8;

    typedef enum logic [1:0] {
        CFG_EXPONENT = 2'd0,
        CFG_MODULUS  = 2'd1,
        CFG_ENCRYPT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIT,
        S_FIN,
        S_RED,
        S_RED_W,
        S_SQ,
        S_SQ_W,
        S_ML,
        S_ML_W,
        S_EMIT,
        S_PADB,
        S_DONE
    } t_state;

    // bit length of a word
    function automatic logic [5:0] bit_len(input logic [CfgBits-1:0] v);
        logic [5:0] k;
        k = 6'd0;
        for (int i = 0; i < CfgBits; i++) begin
            if (v[i]) begin
                k = 6'(i + 1);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rsa_stream_modexp.sv -----
// top level: bit packing, square-and-multiply sequencer and byte repacking
// a chunk takes a reduction, 32 squares and up to 32 multiplies, all on one shared modular
// multiplier, then emits one output bit per cycle while the output does not stall it
// an input byte is taken only in idle, so the next byte waits until every chunk that
// byte completes has been emitted, one byte at a time; a result byte waits in a pending register
// reset: synchronous active low; exponent 65537, modulus 2, encrypt mode, empty buffers
`timescale 1ns / 1ps
`default_nettype none
module rsa_stream_modexp
    import rsm_pkg::*;
#(
    parameter int MAX_KEY_BITS = MaxKeyBits
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in_item           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_item               o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [CfgBits-1:0] i_cfg_data
);

    localparam int W  = MAX_KEY_BITS;
    localparam int FB = $clog2(W + 1);

    t_state r_state, n_state;

    logic [ExpBits-1:0] r_exp;
    logic [W-1:0]       r_n;
    logic [5:0]         r_k;
    logic               r_enc;

    logic [W-1:0]  r_chunk_acc;
    logic [FB-1:0] r_chunk_fill;
    logic [7:0]    r_byte_acc;
    logic [3:0]    r_byte_fill;

    logic [7:0]    r_data;
    logic [3:0]    r_bitcnt;
    logic          r_final;
    logic          r_in_pad;
    logic [W-1:0]  r_base;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_r;
    logic [4:0]    r_idx;
    logic [5:0]    r_ocnt;

    logic          r_pend_valid;
    logic [7:0]    r_pend;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [5:0]    w_in_bits;
    logic [5:0]    w_out_bits;
    logic          w_chunk_full;
    logic          w_out_free;
    logic          w_emit_bit;
    logic          w_byte_full;
    logic          w_emit_stall;
    logic          w_pad_stall;
    logic          w_out_load;
    logic [W-1:0]  w_padded;
    logic [7:0]    w_pad_byte;
    logic          w_mm_start;
    logic [W-1:0]  w_mm_x;
    logic [W-1:0]  w_mm_y;
    logic          w_mm_done;
    logic [W-1:0]  w_mm_res;
    logic [W-1:0]  w_cfg_mod;

    assign w_in_bits    = r_enc ? r_k - 6'd1 : r_k;
    assign w_out_bits   = r_enc ? r_k : r_k - 6'd1;
    assign w_chunk_full = (6'(r_chunk_fill) + 6'd1) >= w_in_bits;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_emit_bit   = r_r[5'(r_ocnt - 6'd1)];
    assign w_byte_full  = (r_byte_fill == 4'd7);
    assign w_emit_stall = w_byte_full && r_pend_valid && !w_out_free;
    assign w_pad_stall  = (r_byte_fill != 4'd0) && r_pend_valid && !w_out_free;
    assign w_padded     = r_chunk_acc << (w_in_bits - 6'(r_chunk_fill));
    assign w_pad_byte   = r_byte_acc << (4'd8 - r_byte_fill);
    assign w_cfg_mod    = (i_cfg_data[W-1:0] < W'(2)) ? W'(2) : i_cfg_data[W-1:0];

    // pending byte moves to the output register
    assign w_out_load = r_pend_valid && (
        (r_state == S_EMIT && !w_emit_stall && w_byte_full) ||
        (r_state == S_PADB && !w_pad_stall && r_byte_fill != 4'd0) ||
        (r_state == S_DONE && w_out_free));

    always_comb begin
        w_mm_start = 1'b0;
        w_mm_x     = r_r;
        w_mm_y     = r_r;
        case (r_state)
            S_RED: begin
                w_mm_start = 1'b1;
                w_mm_x     = W'(1);
                w_mm_y     = r_base;
            end
            S_SQ: w_mm_start = 1'b1;
            S_ML: begin
                w_mm_start = 1'b1;
                w_mm_y     = r_a;
            end
            default: w_mm_start = 1'b0;
        endcase
    end

    rsm_modmul #(.W(W)) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mm_start),
        .i_x     (w_mm_x),
        .i_y     (w_mm_y),
        .i_n     (r_n),
        .o_done  (w_mm_done),
        .o_res   (w_mm_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_BIT;
            S_BIT: begin
                if (w_chunk_full) n_state = S_RED;
                else if (r_bitcnt == 4'd1) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_final) n_state = S_DONE;
                else if (r_chunk_fill != '0) n_state = S_RED;
                else n_state = S_PADB;
            end
            S_RED:   n_state = S_RED_W;
            S_RED_W: if (w_mm_done) n_state = S_SQ;
            S_SQ:    n_state = S_SQ_W;
            S_SQ_W: begin
                if (w_mm_done) begin
                    if (r_exp[r_idx]) n_state = S_ML;
                    else if (r_idx == 5'd0) n_state = S_EMIT;
                    else n_state = S_SQ;
                end
            end
            S_ML:    n_state = S_ML_W;
            S_ML_W: begin
                if (w_mm_done) n_state = (r_idx == 5'd0) ? S_EMIT : S_SQ;
            end
            S_EMIT: begin
                if (!w_emit_stall && r_ocnt == 6'd1) begin
                    if (r_in_pad) n_state = S_PADB;
                    else if (r_bitcnt == 4'd0) n_state = S_FIN;
                    else n_state = S_BIT;
                end
            end
            S_PADB:  if (!w_pad_stall) n_state = S_DONE;
            S_DONE:  if (!r_pend_valid || w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_exp        <= ExpBits'(65537);
            r_n          <= W'(2);
            r_k          <= 6'd2;
            r_enc        <= 1'b1;
            r_chunk_acc  <= '0;
            r_chunk_fill <= '0;
            r_byte_acc   <= '0;
            r_byte_fill  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_in_pad     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_EXPONENT: r_exp <= i_cfg_data;
                    CFG_MODULUS, CFG_ENCRYPT: begin
                        if (i_cfg_idx == CFG_MODULUS) begin
                            r_n <= w_cfg_mod;
                            r_k <= bit_len(CfgBits'(w_cfg_mod));
                        end else begin
                            r_enc <= i_cfg_data[0];
                        end
                        r_chunk_acc  <= '0;
                        r_chunk_fill <= '0;
                        r_byte_acc   <= '0;
                        r_byte_fill  <= '0;
                    end
                    default: r_exp <= r_exp;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_data   <= i_in_data.data_byte;
                        r_final  <= i_in_data.final_byte;
                        r_bitcnt <= 4'd8;
                        r_in_pad <= 1'b0;
                    end
                end
                S_BIT: begin
                    r_data   <= {r_data[6:0], 1'b0};
                    r_bitcnt <= r_bitcnt - 4'd1;
                    if (w_chunk_full) begin
                        r_base       <= {r_chunk_acc[W-2:0], r_data[7]};
                        r_chunk_acc  <= '0;
                        r_chunk_fill <= '0;
                    end else begin
                        r_chunk_acc  <= {r_chunk_acc[W-2:0], r_data[7]};
                        r_chunk_fill <= r_chunk_fill + 1'b1;
                    end
                end
                S_FIN: begin
                    if (r_final && r_chunk_fill != '0) begin
                        r_base       <= w_padded;
                        r_in_pad     <= 1'b1;
                        r_chunk_acc  <= '0;
                        r_chunk_fill <= '0;
                    end
                end
                S_RED_W: begin
                    if (w_mm_done) begin
                        r_a   <= w_mm_res;
                        r_r   <= W'(1);
                        r_idx <= 5'd31;
                    end
                end
                S_SQ_W: begin
                    if (w_mm_done) begin
                        r_r <= w_mm_res;
                        if (!r_exp[r_idx]) begin
                            r_idx <= r_idx - 5'd1;
                            if (r_idx == 5'd0) r_ocnt <= w_out_bits;
                        end
                    end
                end
                S_ML_W: begin
                    if (w_mm_done) begin
                        r_r   <= w_mm_res;
                        r_idx <= r_idx - 5'd1;
                        if (r_idx == 5'd0) r_ocnt <= w_out_bits;
                    end
                end
                S_EMIT: begin
                    if (!w_emit_stall) begin
                        r_ocnt <= r_ocnt - 6'd1;
                        if (w_byte_full) begin
                            r_byte_acc   <= '0;
                            r_byte_fill  <= '0;
                            r_pend       <= {r_byte_acc[6:0], w_emit_bit};
                            r_pend_valid <= 1'b1;
                            if (r_pend_valid) begin
                                r_out.out_byte    <= r_pend;
                                r_out.out_last    <= 1'b0;
                            end
                        end else begin
                            r_byte_acc  <= {r_byte_acc[6:0], w_emit_bit};
                            r_byte_fill <= r_byte_fill + 4'd1;
                        end
                    end
                end
                S_PADB: begin
                    if (!w_pad_stall && r_byte_fill != 4'd0) begin
                        r_byte_acc   <= '0;
                        r_byte_fill  <= '0;
                        r_pend       <= w_pad_byte;
                        r_pend_valid <= 1'b1;
                        if (r_pend_valid) begin
                            r_out.out_byte <= r_pend;
                            r_out.out_last <= 1'b0;
                        end
                    end
                end
                S_DONE: begin
                    if (r_pend_valid && w_out_free) begin
                        r_pend_valid   <= 1'b0;
                        r_out.out_byte <= r_pend;
                        r_out.out_last <= r_final;
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending byte left at idle");
    a_byte_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_fill < 4'd8)
        else $error("byte fill overflow");
    a_chunk_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        6'(r_chunk_fill) < w_in_bits || (r_state == S_IDLE))
        else $error("chunk fill overflow");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out))
        else $error("output transaction overwritten");

endmodule
`default_nettype wire

// ----- rtl/core/rsm_modmul.sv -----
// iterative shift-add modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rsm_modmul
    import rsm_pkg::*;
#(
    parameter int W = MaxKeyBits
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_y,
    input  wire logic [W-1:0] i_n,
    output logic              o_done,
    output logic [W-1:0]      o_res
);

    localparam int CntBits = $clog2(W + 1);

    logic               r_busy;
    logic [CntBits-1:0] r_cnt;
    logic [W-1:0]       r_acc;
    logic [W-1:0]       r_x;
    logic [W-1:0]       r_y;
    logic [W-1:0]       r_n;
    logic               r_done;

    logic [W:0] w_dbl;
    logic [W:0] w_dbl_red;
    logic [W:0] w_sum;
    logic [W:0] w_sum_red;

    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_n}) ? w_dbl - {1'b0, r_n} : w_dbl;
        w_sum     = r_y[W-1] ? w_dbl_red + {1'b0, r_x} : w_dbl_red;
        w_sum_red = (w_sum >= {1'b0, r_n}) ? w_sum - {1'b0, r_n} : w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntBits'(W);
                r_acc  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_n    <= i_n;
            end else if (r_busy) begin
                r_acc <= w_sum_red[W-1:0];
                r_y   <= {r_y[W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntBits'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < r_n))
        else $error("modmul result not reduced");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("modmul restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("modmul done held");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the streaming modexp block: queued driver, monitor and byte predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import rsm_pkg::*;

    localparam int WatchLimit = 400000;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    t_in_item            in_data;
    logic                out_valid;
    logic                out_ready;
    t_out_item           out_data;
    logic                cfg_we;
    logic [1:0]          cfg_idx;
    logic [CfgBits-1:0]  cfg_data;

    rsa_stream_modexp u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // predictor copy of key and packing state
    logic [31:0] key_exp;
    logic [31:0] key_mod;
    logic        key_enc;
    logic [31:0] chunk_bits;
    int unsigned chunk_cnt;
    logic [7:0]  obyte_bits;
    int unsigned obyte_cnt;

    t_in_item  byte_queue[$];
    t_out_item expected_bytes[$];
    int        n_fail = 0;
    int        watch_cnt;
    bit        in_sent;
    bit        out_sent;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // handshakes seen at the last rising edge
    always @(posedge i_clk) begin
        in_sent  <= in_valid && in_ready;
        out_sent <= out_valid && out_ready;
    end

    function automatic logic [31:0] mod_power(logic [31:0] b, logic [31:0] e, logic [31:0] n);
        logic [63:0] r;
        logic [63:0] a;
        r = 64'(1) % n;
        a = 64'(b) % n;
        for (int i = 31; i >= 0; i--) begin
            r = (r * r) % n;
            if (e[i]) begin
                r = (r * a) % n;
            end
        end
        return r[31:0];
    endfunction

    function automatic int unsigned mod_len();
        logic [31:0] m;
        int unsigned k;
        m = (key_mod < 2) ? 32'd2 : key_mod;
        k = 0;
        while (m != 0) begin
            k++;
            m = m >> 1;
        end
        return k;
    endfunction

    task automatic push_bit(input logic b, inout int produced);
        t_out_item o;
        obyte_bits = {obyte_bits[6:0], b};
        obyte_cnt++;
        if (obyte_cnt >= 8) begin
            o.out_byte = obyte_bits;
            o.out_last = 1'b0;
            expected_bytes.insert(expected_bytes.size(), o);
            produced++;
            obyte_bits = '0;
            obyte_cnt = 0;
        end
    endtask

    task automatic emit_chunk(input logic [31:0] c, input int unsigned nbits,
                              inout int produced);
        logic [31:0] r;
        r = mod_power(c, key_exp, (key_mod < 2) ? 32'd2 : key_mod);
        for (int i = int'(nbits) - 1; i >= 0; i--) begin
            push_bit(r[i], produced);
        end
    endtask

    task automatic predict_bytes(input t_in_item it);
        int unsigned k;
        int unsigned nin;
        int unsigned nout;
        int produced;
        t_out_item o;
        k = mod_len();
        nin = key_enc ? k - 1 : k;
        nout = key_enc ? k : k - 1;
        produced = 0;
        for (int i = 7; i >= 0; i--) begin
            chunk_bits = {chunk_bits[30:0], it.data_byte[i]};
            chunk_cnt++;
            if (chunk_cnt >= nin) begin
                emit_chunk(chunk_bits, nout, produced);
                chunk_bits = '0;
                chunk_cnt = 0;
            end
        end
        if (it.final_byte) begin
            if (chunk_cnt != 0) begin
                emit_chunk(chunk_bits << (nin - chunk_cnt), nout, produced);
                chunk_bits = '0;
                chunk_cnt = 0;
            end
            if (obyte_cnt != 0) begin
                o.out_byte = obyte_bits << (8 - obyte_cnt);
                o.out_last = 1'b0;
                expected_bytes.insert(expected_bytes.size(), o);
                produced++;
                obyte_bits = '0;
                obyte_cnt = 0;
            end
            if (produced > 0) begin
                expected_bytes[$].out_last = 1'b1;
            end
        end
    endtask

    // driver
    int in_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap <= 0;
        end else if (in_valid && !in_sent) begin
        end else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (byte_queue.size() > 0) begin
            in_valid <= 1'b1;
            in_data <= byte_queue.pop_front();
            in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // receiver stall, with long hold-offs after some transactions
    int out_gap;
    int hold_cnt;
    int rx_cnt;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_gap <= 0;
            hold_cnt <= 0;
            rx_cnt <= 0;
        end else if (hold_cnt > 0) begin
            out_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (out_gap > 0) begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else if (out_sent) begin
            out_ready <= 1'b0;
            rx_cnt <= rx_cnt + 1;
            if (rx_cnt == 60 || rx_cnt == 250) begin
                hold_cnt <= 3000;
            end
            out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            key_exp = 32'd65537;
            key_mod = 32'd2;
            key_enc = 1'b1;
            chunk_bits = '0;
            chunk_cnt = 0;
            obyte_bits = '0;
            obyte_cnt = 0;
            watch_cnt <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_EXPONENT: key_exp = cfg_data;
                    CFG_MODULUS: key_mod = cfg_data;
                    CFG_ENCRYPT: key_enc = cfg_data[0];
                    default: ;
                endcase
                if (cfg_idx == CFG_MODULUS || cfg_idx == CFG_ENCRYPT) begin
                    chunk_bits = '0;
                    chunk_cnt = 0;
                    obyte_bits = '0;
                    obyte_cnt = 0;
                end
            end
            if (in_valid && in_ready) begin
                predict_bytes(in_data);
            end
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected transaction actual %h/%b", $time,
                             out_data.out_byte, out_data.out_last);
                    n_fail++;
                end else begin
                    e = expected_bytes.pop_front();
                    if (e.out_byte !== out_data.out_byte) begin
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 e.out_byte, out_data.out_byte);
                        n_fail++;
                    end
                    if (e.out_last !== out_data.out_last) begin
                        $display("%0t: out_last expected %b actual %b", $time,
                                 e.out_last, out_data.out_last);
                        n_fail++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (byte_queue.size() == 0 && !in_valid && expected_bytes.size() == 0)) begin
                watch_cnt <= 0;
            end else begin
                watch_cnt <= watch_cnt + 1;
                if (watch_cnt >= WatchLimit) begin
                    $display("tb_top failed");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (byte_queue.size() > 0 || in_valid || expected_bytes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (6000) @(posedge i_clk);
    endtask

    task automatic queue_byte(input logic [7:0] d, input logic f);
        t_in_item it;
        it.data_byte = d;
        it.final_byte = f;
        byte_queue.insert(byte_queue.size(), it);
    endtask

    task automatic random_message(input int len);
        for (int i = 0; i < len; i++) begin
            queue_byte($urandom_range(0, 255), i == len - 1);
        end
    endtask

    initial begin
        logic [31:0] mods[6];
        logic [31:0] exps[6];
        cfg_we = 1'b0;
        cfg_idx = CFG_EXPONENT;
        cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset key: modulus 2, single-bit chunks
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hA5, 1'b1);
        drain();

        // small modulus, zero exponent, decrypt unreduced chunks
        write_reg(CFG_MODULUS, 32'd0);
        write_reg(CFG_EXPONENT, 32'd0);
        queue_byte(8'h5A, 1'b1);
        drain();
        write_reg(CFG_MODULUS, 32'd11);
        write_reg(CFG_ENCRYPT, 32'd0);
        write_reg(CFG_EXPONENT, 32'd7);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h0F, 1'b1);
        drain();

        // largest modulus and exponent
        write_reg(CFG_MODULUS, 32'hFFFF_FFFF);
        write_reg(CFG_ENCRYPT, 32'd1);
        write_reg(CFG_EXPONENT, 32'hFFFF_FFFF);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b1);
        drain();

        // key change mid-message clears partial bits
        write_reg(CFG_MODULUS, 32'd3233);
        write_reg(CFG_EXPONENT, 32'd17);
        queue_byte(8'h3C, 1'b0);
        drain();
        write_reg(CFG_MODULUS, 32'd3233);
        queue_byte(8'hC3, 1'b1);
        drain();

        mods = '{32'd5, 32'd3233, 32'd65521, 32'h0001_0001, 32'h8000_000B, 32'hFFFF_FFFB};
        exps = '{32'd3, 32'd17, 32'd65537, 32'd2753, 32'h1234_5677, 32'hFFFF_FFFF};
        for (int ph = 0; ph < 12; ph++) begin
            int budget;
            write_reg(CFG_MODULUS, mods[$urandom_range(0, 5)] | 32'($urandom_range(0, 1)));
            write_reg(CFG_EXPONENT, ($urandom_range(0, 4) == 0) ? $urandom()
                      : exps[$urandom_range(0, 5)]);
            write_reg(CFG_ENCRYPT, $urandom_range(0, 1));
            budget = 0;
            while (budget < 36) begin
                int len;
                len = $urandom_range(1, 8);
                if ($urandom_range(0, 9) == 0) begin
                    queue_byte($urandom_range(0, 255), 1'b0);
                    budget++;
                end
                random_message(len);
                budget += len;
            end
            drain();
        end

        if (n_fail == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/rsm_pkg.sv
rtl/core/rsm_modmul.sv
rtl/core/rsa_stream_modexp.sv
tb/tb_top.sv
